>>> rtl/core/wncg_pkg.sv
// Shared types, register codes and helpers for the window coordinate generator.
`timescale 1ns / 1ps
package wncg_pkg;

    // Widths that the register map and the largest supported radius fix.
    localparam int RAD_W      = 3;
    localparam int OFF_W      = RAD_W + 1;
    localparam int SQ_W       = 2 * RAD_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int IMG_W      = 13;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISC_SHAPE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RASTER_ORDER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUNDS_CHECK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS   = 3'd5;

    // Per-request window mode, captured when the center is taken.
    typedef struct packed {
        logic [RAD_W-1:0] rad;
        logic             disc;
        logic             raster;
        logic             bchk;
    } t_mode;

    // Image size used by the bounds check.
    typedef struct packed {
        logic [IMG_W-1:0] rows;
        logic [IMG_W-1:0] cols;
    } t_img;

    // Square of a small signed offset.
    function automatic logic [SQ_W-1:0] off_sq(input logic signed [OFF_W-1:0] v);
        logic [OFF_W-1:0] mag;
        logic [SQ_W-1:0]  mz;
        mag = v[OFF_W-1] ? (~v + 1'b1) : v;
        mz  = SQ_W'(mag[RAD_W-1:0]);
        return mz * mz;
    endfunction

endpackage

>>> rtl/core/wncg_fifo.sv
// Small register queue used between the front, the back and the result port.
`timescale 1ns / 1ps
module wncg_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    // Pointers wrap at the depth; the count tracks occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_mem[r_wp] <= i_data;
                r_wp        <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/wncg_front.sv
// Front end: configuration registers, center intake and the request queue.
`timescale 1ns / 1ps
module wncg_front #(
    parameter int MAX_RADIUS = 3,
    parameter int COORD_BITS = 12
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    output logic                               o_full,
    input  logic [COORD_BITS-1:0]              i_center_row,
    input  logic [COORD_BITS-1:0]              i_center_col,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [wncg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [wncg_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output wncg_pkg::t_img                     o_img,
    output logic                               o_ent_vld,
    output wncg_pkg::t_mode                    o_ent_mode,
    output logic [COORD_BITS-1:0]              o_ent_row,
    output logic [COORD_BITS-1:0]              o_ent_col,
    input  logic                               i_ent_pop
);
    import wncg_pkg::*;

    localparam int EW = $bits(t_mode) + 2 * COORD_BITS;

    logic [1:0]       r_radius;
    logic             r_disc;
    logic             r_raster;
    logic             r_bchk;
    logic [IMG_W-1:0] r_rows;
    logic [IMG_W-1:0] r_cols;
    t_mode            mode;
    logic [EW-1:0]    ent_in;
    logic [EW-1:0]    ent_out;
    logic             q_empty;

    assign o_cfg_ready = 1'b1;

    // Register writes; indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 2'd1;
            r_disc   <= 1'b0;
            r_raster <= 1'b0;
            r_bchk   <= 1'b1;
            r_rows   <= IMG_W'(4096);
            r_cols   <= IMG_W'(4096);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RADIUS:       r_radius <= i_cfg_data[1:0];
                CFG_DISC_SHAPE:   r_disc   <= i_cfg_data[0];
                CFG_RASTER_ORDER: r_raster <= i_cfg_data[0];
                CFG_BOUNDS_CHECK: r_bchk   <= i_cfg_data[0];
                CFG_IMAGE_ROWS:   r_rows   <= i_cfg_data[IMG_W-1:0];
                CFG_IMAGE_COLS:   r_cols   <= i_cfg_data[IMG_W-1:0];
                default: ;
            endcase
        end
    end

    // Classify the request: saturate the radius and attach the window mode.
    always_comb begin
        if ({{(RAD_W-2){1'b0}}, r_radius} > RAD_W'(MAX_RADIUS)) begin
            mode.rad = RAD_W'(MAX_RADIUS);
        end else begin
            mode.rad = {{(RAD_W-2){1'b0}}, r_radius};
        end
        mode.disc   = r_disc;
        mode.raster = r_raster;
        mode.bchk   = r_bchk;
    end

    assign ent_in      = {mode, i_center_row, i_center_col};
    assign o_img.rows  = r_rows;
    assign o_img.cols  = r_cols;

    wncg_fifo #(
        .W     (EW),
        .DEPTH (2)
    ) u_req_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (ent_in),
        .o_full  (o_full),
        .i_pop   (i_ent_pop),
        .o_data  (ent_out),
        .o_empty (q_empty)
    );

    assign o_ent_vld = !q_empty;
    assign {o_ent_mode, o_ent_row, o_ent_col} = ent_out;

endmodule

>>> rtl/core/wncg_back.sv
// Back end: offset sequencer, window and bounds filter, and held-point tagging.
`timescale 1ns / 1ps
module wncg_back #(
    parameter int COORD_BITS = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  wncg_pkg::t_img               i_img,
    input  logic                         i_ent_vld,
    input  wncg_pkg::t_mode              i_ent_mode,
    input  logic [COORD_BITS-1:0]        i_ent_row,
    input  logic [COORD_BITS-1:0]        i_ent_col,
    output logic                         o_ent_pop,
    input  logic                         i_out_full,
    output logic                         o_out_push,
    output logic signed [COORD_BITS+1:0] o_out_row,
    output logic signed [COORD_BITS+1:0] o_out_col,
    output logic                         o_out_valid_res,
    output logic                         o_out_last
);
    import wncg_pkg::*;

    localparam int CW   = COORD_BITS;
    localparam int OW   = COORD_BITS + 2;
    localparam int CMPW = ((OW > IMG_W) ? OW : IMG_W) + 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SWEEP = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]               r_state;
    logic signed [OFF_W-1:0]  r_a;
    logic signed [OFF_W-1:0]  r_b;
    logic [1:0]               r_q;
    logic [CW-1:0]            r_crow;
    logic [CW-1:0]            r_ccol;
    t_mode                    r_mode;
    logic                     r_hvld;
    logic [OW-1:0]            r_hrow;
    logic [OW-1:0]            r_hcol;

    logic signed [OFF_W-1:0]  rad_s;
    logic signed [OFF_W-1:0]  dr;
    logic signed [OFF_W-1:0]  dc;
    logic signed [OFF_W-1:0]  n_a;
    logic signed [OFF_W-1:0]  n_b;
    logic [1:0]               n_q;
    logic                     cand_end;
    logic                     disc_ok;
    logic signed [CMPW-1:0]   rsum;
    logic signed [CMPW-1:0]   csum;
    logic                     in_ok;
    logic                     pass;
    logic                     step;
    logic                     flush_go;

    assign rad_s = $signed({1'b0, r_mode.rad});

    // Offset of the current candidate point.
    always_comb begin
        dr = '0;
        dc = '0;
        if (r_mode.raster) begin
            dr = r_a;
            dc = r_b;
        end else if (r_a == '0) begin
            dr = '0;
            dc = '0;
        end else if (r_b == '0) begin
            case (r_q)
                2'd0: begin dr = -r_a; dc = '0;   end
                2'd1: begin dr = r_a;  dc = '0;   end
                2'd2: begin dr = '0;   dc = -r_a; end
                default: begin dr = '0; dc = r_a; end
            endcase
        end else begin
            case (r_q)
                2'd0: begin dr = -r_a; dc = -r_b; end
                2'd1: begin dr = -r_a; dc = r_b;  end
                2'd2: begin dr = r_a;  dc = -r_b; end
                default: begin dr = r_a; dc = r_b; end
            endcase
        end
    end

    // Next candidate; cand_end marks the final point of the window.
    always_comb begin
        n_a      = r_a;
        n_b      = r_b;
        n_q      = r_q;
        cand_end = 1'b0;
        if (r_mode.raster) begin
            if (r_b != rad_s) begin
                n_b = r_b + 1'b1;
            end else begin
                n_b = -rad_s;
                if (r_a != rad_s) begin
                    n_a = r_a + 1'b1;
                end else begin
                    cand_end = 1'b1;
                end
            end
        end else if (r_a == '0) begin
            if (rad_s == '0) begin
                cand_end = 1'b1;
            end else begin
                n_a = OFF_W'(1);
                n_b = '0;
                n_q = 2'd0;
            end
        end else if (r_q != 2'd3) begin
            n_q = r_q + 1'b1;
        end else begin
            n_q = 2'd0;
            if (r_b != rad_s) begin
                n_b = r_b + 1'b1;
            end else begin
                n_b = '0;
                if (r_a != rad_s) begin
                    n_a = r_a + 1'b1;
                end else begin
                    cand_end = 1'b1;
                end
            end
        end
    end

    // Disc shape and image bounds filter.
    always_comb begin
        disc_ok = !r_mode.disc || ((off_sq(dr) + off_sq(dc)) <= off_sq(rad_s));
        rsum    = $signed({{(CMPW-CW){1'b0}}, r_crow}) +
                  $signed({{(CMPW-OFF_W){dr[OFF_W-1]}}, dr});
        csum    = $signed({{(CMPW-CW){1'b0}}, r_ccol}) +
                  $signed({{(CMPW-OFF_W){dc[OFF_W-1]}}, dc});
        in_ok   = !rsum[CMPW-1] && !csum[CMPW-1] &&
                  (rsum < $signed({{(CMPW-IMG_W){1'b0}}, i_img.rows})) &&
                  (csum < $signed({{(CMPW-IMG_W){1'b0}}, i_img.cols}));
        pass    = disc_ok && (!r_mode.bchk || in_ok);
    end

    assign step      = (r_state == ST_SWEEP) && !i_out_full;
    assign flush_go  = (r_state == ST_FLUSH) && !i_out_full;
    assign o_ent_pop = (r_state == ST_IDLE) && i_ent_vld;

    // A point is sent once the next passing point proves it is not the last.
    assign o_out_push      = (step && pass && r_hvld) || flush_go;
    assign o_out_row       = (r_state == ST_FLUSH && !r_hvld) ? '0 : $signed(r_hrow);
    assign o_out_col       = (r_state == ST_FLUSH && !r_hvld) ? '0 : $signed(r_hcol);
    assign o_out_valid_res = (r_state == ST_FLUSH) ? r_hvld : 1'b1;
    assign o_out_last      = (r_state == ST_FLUSH);

    // Sequencer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_hvld  <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_ent_vld) begin
                        r_mode  <= i_ent_mode;
                        r_crow  <= i_ent_row;
                        r_ccol  <= i_ent_col;
                        r_q     <= 2'd0;
                        r_hvld  <= 1'b0;
                        if (i_ent_mode.raster) begin
                            r_a <= -$signed({1'b0, i_ent_mode.rad});
                            r_b <= -$signed({1'b0, i_ent_mode.rad});
                        end else begin
                            r_a <= '0;
                            r_b <= '0;
                        end
                        r_state <= ST_SWEEP;
                    end
                end
                ST_SWEEP: begin
                    if (step) begin
                        if (pass) begin
                            r_hvld <= 1'b1;
                            r_hrow <= rsum[OW-1:0];
                            r_hcol <= csum[OW-1:0];
                        end
                        r_a <= n_a;
                        r_b <= n_b;
                        r_q <= n_q;
                        if (cand_end) begin
                            r_state <= ST_FLUSH;
                        end
                    end
                end
                ST_FLUSH: begin
                    if (flush_go) begin
                        r_hvld  <= 1'b0;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/core/window_neighbor_coordinate_generator_unit.sv
// Window neighbor coordinate generator: top level.
// For each center request it emits every coordinate of a square or disc window of
// radius 0..3 (saturated at MAX_RADIUS), in center-first order or raster order,
// dropping points outside the image when the bounds check is on; the final result of
// a center carries last, and a center with no surviving point gives one result with
// valid_res low and zero coordinates. A center occupies the back-end sequencer while it
// loads the request, tests one window point per cycle while the result queue has room,
// and tags the final result; a two-entry request queue lets new centers be pushed
// meanwhile, and a two-entry result queue decouples pop. Configuration
// writes are taken every cycle and must only happen while the block is idle.
`timescale 1ns / 1ps
module window_neighbor_coordinate_generator_unit #(
    parameter int MAX_RADIUS = 3,
    parameter int COORD_BITS = 12
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [COORD_BITS-1:0]              i_center_row,
    input  logic [COORD_BITS-1:0]              i_center_col,
    output logic                               empty,
    input  logic                               pop,
    output logic signed [COORD_BITS+1:0]       o_neighbor_row,
    output logic signed [COORD_BITS+1:0]       o_neighbor_col,
    output logic                               o_valid_res,
    output logic                               o_last,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [wncg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [wncg_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import wncg_pkg::*;

    localparam int OW = COORD_BITS + 2;
    localparam int RW = 2 * OW + 2;

    t_img                   img;
    logic                   ent_vld;
    t_mode                  ent_mode;
    logic [COORD_BITS-1:0]  ent_row;
    logic [COORD_BITS-1:0]  ent_col;
    logic                   ent_pop;
    logic                   res_full;
    logic                   res_push;
    logic signed [OW-1:0]   res_row;
    logic signed [OW-1:0]   res_col;
    logic                   res_vld;
    logic                   res_last;
    logic [RW-1:0]          res_out;

    wncg_front #(
        .MAX_RADIUS (MAX_RADIUS),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_center_row (i_center_row),
        .i_center_col (i_center_col),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_img        (img),
        .o_ent_vld    (ent_vld),
        .o_ent_mode   (ent_mode),
        .o_ent_row    (ent_row),
        .o_ent_col    (ent_col),
        .i_ent_pop    (ent_pop)
    );

    wncg_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_img           (img),
        .i_ent_vld       (ent_vld),
        .i_ent_mode      (ent_mode),
        .i_ent_row       (ent_row),
        .i_ent_col       (ent_col),
        .o_ent_pop       (ent_pop),
        .i_out_full      (res_full),
        .o_out_push      (res_push),
        .o_out_row       (res_row),
        .o_out_col       (res_col),
        .o_out_valid_res (res_vld),
        .o_out_last      (res_last)
    );

    // Result queue toward the consumer.
    wncg_fifo #(
        .W     (RW),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  ({res_row, res_col, res_vld, res_last}),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_neighbor_row = $signed(res_out[RW-1 -: OW]);
    assign o_neighbor_col = $signed(res_out[OW+1 -: OW]);
    assign o_valid_res    = res_out[1];
    assign o_last         = res_out[0];

endmodule

>>> rtl/core/wncg_checker.sv
// Port-level checks for the window coordinate generator, bound to the top level.
`timescale 1ns / 1ps
module wncg_checker #(
    parameter int COORD_BITS = 12
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         push,
    input logic                         full,
    input logic                         empty,
    input logic                         pop,
    input logic signed [COORD_BITS+1:0] o_neighbor_row,
    input logic signed [COORD_BITS+1:0] o_neighbor_col,
    input logic                         o_valid_res,
    input logic                         o_last
);

    // Reset leaves no result waiting and room for a request.
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not clear after reset");

    // An empty-window result always closes its center.
    a_invalid_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_valid_res) |-> o_last)
        else $error("invalid result without last");

    // An empty-window result carries zero coordinates.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_valid_res) |-> (o_neighbor_row == '0 && o_neighbor_col == '0))
        else $error("invalid result with nonzero coordinates");

    // A waiting result holds until it is popped.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_neighbor_row) &&
                              $stable(o_neighbor_col) && $stable(o_valid_res) &&
                              $stable(o_last)))
        else $error("waiting result changed before pop");

endmodule

bind window_neighbor_coordinate_generator_unit wncg_checker #(
    .COORD_BITS (COORD_BITS)
) u_wncg_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .push           (push),
    .full           (full),
    .empty          (empty),
    .pop            (pop),
    .o_neighbor_row (o_neighbor_row),
    .o_neighbor_col (o_neighbor_col),
    .o_valid_res    (o_valid_res),
    .o_last         (o_last)
);
